FILE: rtl/assert_macros.svh
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/cah_pkg.sv
// shared types, constants and tables of the compass calibrate and heading block
package cah_pkg;

    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int CFG_W     = 15;
    localparam int HEAD_W    = 17;
    localparam int HEAD_PAD  = 24;
    localparam int GAIN_W    = 27;
    localparam int ANG_FRAC  = 12;
    localparam int ANG_W     = 29;
    localparam int ANGLE_W   = 15;
    localparam int DIV_STEPS = 27;
    localparam int CNT_W     = 5;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_RESET = 27'd65536;
    localparam logic [GAIN_W-1:0] GAIN_NUM   = 27'd67108864;

    localparam logic signed [ANG_W-1:0] FULL_TURN_Z = 29'sd94371840;
    localparam logic signed [ANG_W-1:0] HALF_TURN_Z = 29'sd47185920;
    localparam logic signed [ANG_W-1:0] ROUND_HALF  = 29'sd2048;
    localparam logic [ANGLE_W+1:0]      FULL_TURN   = 17'd23040;

    localparam logic signed [CFG_W-1:0] DECL_RESET = 15'sd704;
    localparam logic signed [CFG_W-1:0] OFF_RESET  = 15'sd2240;

    // command kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // configuration register indexes
    localparam logic CFG_DECLINATION = 1'b0;
    localparam logic CFG_OFFSET      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_DIV, S_COMMIT, S_INIT, S_ROT, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic             load_in;
        logic             seed;
        logic             widen;
        logic             div_start;
        logic             div_step;
        logic             div_commit;
        logic             mul;
        logic             cordic_init;
        logic             cordic_step;
        logic             finish;
        logic             load_out;
        logic [CNT_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       calibrating;
        logic       out_busy;
    } t_sts;

    // atan(2^-i) in 2^-12 of 1/64 degree
    function automatic logic [ANG_W-1:0] atan_at(input logic [CNT_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 29'd11796480;
            5'd1:    v = 29'd6963869;
            5'd2:    v = 29'd3679517;
            5'd3:    v = 29'd1867780;
            5'd4:    v = 29'd937515;
            5'd5:    v = 29'd469214;
            5'd6:    v = 29'd234664;
            5'd7:    v = 29'd117339;
            5'd8:    v = 29'd58671;
            5'd9:    v = 29'd29335;
            5'd10:   v = 29'd14668;
            5'd11:   v = 29'd7334;
            5'd12:   v = 29'd3667;
            5'd13:   v = 29'd1833;
            5'd14:   v = 29'd917;
            5'd15:   v = 29'd458;
            5'd16:   v = 29'd229;
            5'd17:   v = 29'd115;
            5'd18:   v = 29'd57;
            5'd19:   v = 29'd29;
            5'd20:   v = 29'd14;
            5'd21:   v = 29'd7;
            5'd22:   v = 29'd4;
            5'd23:   v = 29'd2;
            default: v = 29'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/cah_ctrl.sv
// controller state machine of the compass block
`include "assert_macros.svh"
module cah_ctrl
    import cah_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [CNT_W-1:0] LAST_ROT = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.step = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_cnt   = '0;
                case (i_sts.kind)
                    KIND_START:  o_cmd.seed = 1'b1;
                    KIND_FINISH: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    KIND_SAMPLE: begin
                        if (i_sts.calibrating) begin
                            o_cmd.widen = 1'b1;
                        end else begin
                            o_cmd.mul = 1'b1;
                            n_state   = S_INIT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_DIV) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.div_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_cnt             = '0;
                n_state           = S_ROT;
            end
            S_ROT: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt             = r_cnt + 1'b1;
                if (r_cnt == LAST_ROT) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_DECODE)
    `ASSERT_NEXT(a_rot_end, i_clk, i_rst_n, (r_state == S_ROT) && (r_cnt == LAST_ROT), r_state == S_FIN)
    `ASSERT_IMPL(a_div_bound, i_clk, i_rst_n, r_state == S_DIV, r_cnt <= LAST_DIV)
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.load_out, !i_sts.out_busy)

endmodule

FILE: rtl/cah_dp.sv
// datapath: calibration state, gain divider, scaling multiplier, cordic and output register
module cah_dp
    import cah_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wen,
    input  logic                     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic [1:0]               i_kind,
    input  logic [SAMPLE_BITS-1:0]   i_sample_x,
    input  logic [SAMPLE_BITS-1:0]   i_sample_y,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [HEAD_W-1:0]        o_heading
);

    localparam int S      = SAMPLE_BITS;
    localparam int D_W    = S + 1;
    localparam int SPAN_W = S + 1;
    localparam int REM_W  = S + 2;
    localparam int P_W    = S + 29;
    localparam int C_W    = P_W + 2;

    logic [1:0]                r_kind;
    logic signed [S-1:0]       r_s [2];
    logic                      r_calib;
    logic signed [S-1:0]       r_min [2];
    logic signed [S-1:0]       r_max [2];
    logic signed [S-1:0]       r_center [2];
    logic [GAIN_W-1:0]         r_gain [2];
    logic signed [CFG_W-1:0]   r_decl, r_off;
    logic [GAIN_W-1:0]         r_num [2];
    logic [REM_W-1:0]          r_rem [2];
    logic [GAIN_W-1:0]         r_quo [2];
    logic [SPAN_W-1:0]         r_span [2];
    logic                      r_sat [2];
    logic signed [P_W-1:0]     r_p [2];
    logic signed [C_W-1:0]     r_cx, r_cy;
    logic signed [ANG_W-1:0]   r_cz;
    logic                      r_zero;
    logic signed [HEAD_W-1:0]  r_head;
    logic                      r_out_valid;
    logic [HEAD_W-1:0]         r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
            r_off  <= OFF_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_DECLINATION: r_decl <= i_cfg_wdata;
                CFG_OFFSET:      r_off  <= i_cfg_wdata;
                default:         r_off  <= r_off;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_s[0] <= i_sample_x;
            r_s[1] <= i_sample_y;
        end
    end

    // calibration state and gain divider, one quotient bit per cycle per axis
    always_ff @(posedge i_clk) begin
        logic signed [SPAN_W-1:0] span;
        logic signed [SPAN_W-1:0] sum;
        logic [REM_W-1:0]         rsh;
        logic [REM_W-1:0]         den;
        if (!i_rst_n) begin
            r_calib <= 1'b0;
            for (int a = 0; a < 2; a++) begin
                r_min[a]    <= '0;
                r_max[a]    <= '0;
                r_center[a] <= '0;
                r_gain[a]   <= GAIN_RESET;
            end
        end else begin
            if (i_cmd.seed) begin
                r_calib <= 1'b1;
            end
            if (i_cmd.div_commit) begin
                r_calib <= 1'b0;
            end
            for (int a = 0; a < 2; a++) begin
                span = SPAN_W'(r_max[a]) - SPAN_W'(r_min[a]);
                sum  = SPAN_W'(r_max[a]) + SPAN_W'(r_min[a]);
                rsh  = {r_rem[a][REM_W-2:0], r_num[a][GAIN_W-1]};
                den  = REM_W'(r_span[a]);
                if (i_cmd.seed) begin
                    r_min[a] <= r_s[a];
                    r_max[a] <= r_s[a];
                end
                if (i_cmd.widen) begin
                    if (r_s[a] < r_min[a]) r_min[a] <= r_s[a];
                    if (r_s[a] > r_max[a]) r_max[a] <= r_s[a];
                end
                if (i_cmd.div_start) begin
                    r_center[a] <= S'(sum >>> 1);
                    r_span[a]   <= span;
                    r_sat[a]    <= (span <= 0);
                    r_num[a]    <= GAIN_NUM + GAIN_W'(span[SPAN_W-1:1]);
                    r_rem[a]    <= '0;
                    r_quo[a]    <= '0;
                end
                if (i_cmd.div_step) begin
                    r_num[a] <= {r_num[a][GAIN_W-2:0], 1'b0};
                    if (rsh >= den) begin
                        r_rem[a] <= rsh - den;
                        r_quo[a] <= {r_quo[a][GAIN_W-2:0], 1'b1};
                    end else begin
                        r_rem[a] <= rsh;
                        r_quo[a] <= {r_quo[a][GAIN_W-2:0], 1'b0};
                    end
                end
                if (i_cmd.div_commit) begin
                    r_gain[a] <= r_sat[a] ? GAIN_MAX : r_quo[a];
                end
            end
        end
    end

    // centering and gain multiply
    always_ff @(posedge i_clk) begin
        logic signed [D_W-1:0] diff;
        if (i_cmd.mul) begin
            for (int a = 0; a < 2; a++) begin
                diff   = D_W'(r_s[a]) - D_W'(r_center[a]);
                r_p[a] <= P_W'(diff * $signed({1'b0, r_gain[a]}));
            end
        end
    end

    // cordic vectoring, one rotation per cycle
    always_ff @(posedge i_clk) begin
        logic signed [C_W-1:0] x0, y0, xs, ys;
        x0 = C_W'(r_p[0]);
        y0 = C_W'(r_p[1]);
        xs = r_cx >>> i_cmd.step;
        ys = r_cy >>> i_cmd.step;
        if (i_cmd.cordic_init) begin
            r_zero <= (r_p[0] == '0) && (r_p[1] == '0);
            if (x0 < 0) begin
                r_cx <= -x0;
                r_cy <= -y0;
                r_cz <= HALF_TURN_Z;
            end else begin
                r_cx <= x0;
                r_cy <= y0;
                r_cz <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + $signed(atan_at(i_cmd.step));
            end else begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - $signed(atan_at(i_cmd.step));
            end
        end
    end

    // wrap, round to 1/64 degree and add declination and offset
    always_ff @(posedge i_clk) begin
        logic signed [ANG_W-1:0] zw, zr;
        logic [ANGLE_W+1:0]      ang;
        zw  = (r_cz < 0) ? r_cz + FULL_TURN_Z : r_cz;
        zr  = (zw + ROUND_HALF) >>> ANG_FRAC;
        ang = zr[ANGLE_W+1:0];
        if (ang >= FULL_TURN) ang = ang - FULL_TURN;
        if (r_zero) ang = '0;
        if (i_cmd.finish) begin
            r_head <= $signed(ang) + HEAD_W'(r_decl) + HEAD_W'(r_off);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= r_head;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_heading        = r_out_data;
    assign o_sts.kind        = r_kind;
    assign o_sts.calibrating = r_calib;
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

endmodule

FILE: rtl/compass_calibrate_and_heading.sv
// top level of the compass calibrate and heading block
// usage:
//   slave stream: tuser carries the command kind (sample, start, finish),
//   tdata carries sample x (low bits) and sample y. a start command seeds
//   the per-axis min and max, samples while calibrating widen them, and
//   finish sets center and gain 2^26/span through a bit-serial divider.
//   other samples give one heading transfer on the master stream, in
//   1/64 degree, with declination and mounting offset added.
//   throughput: one item at a time. a heading sample passes capture,
//   decode with gain multiply, cordic setup, one cordic rotation per
//   cycle, rounding and output load; finish steps the divider through
//   its 27 quotient bits, then commits; other commands end after decode.
//   the output register holds a finished heading while the next item is
//   taken; if the receiver stalls, the next heading waits in the block and
//   the slave side stays not ready until the output register frees.
//   reset: not calibrating, min, max and center zero, unity gain,
//   declination 704 and offset 2240. config writes take effect at once.
module compass_calibrate_and_heading
    import cah_pkg::*;
#(
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic                                i_cfg_idx,
    input  logic [CFG_W-1:0]                    i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields: sample_x, sample_y
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // fields: kind
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields: heading
    output logic [HEAD_PAD-1:0]                 m_axis_tdata
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [HEAD_W-1:0] w_heading;

    cah_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cah_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_axis_tuser),
        .i_sample_x  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_sample_y  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_heading   (w_heading)
    );

    assign m_axis_tdata = {{(HEAD_PAD-HEAD_W){1'b0}}, w_heading};

endmodule

FILE: tb/compass_calibrate_and_heading_tb.sv
// testbench for the compass calibrate and heading block: calibration commands and headings
`timescale 1ns / 1ps

module compass_calibrate_and_heading_tb;
    import cah_pkg::*;

    localparam int SB = DEF_SAMPLE_BITS;
    localparam int STEPS = DEF_CORDIC_STEPS;
    localparam int DW = ((2*SB+7)/8)*8;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_item;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wen;
    logic i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [HEAD_PAD-1:0] m_axis_tdata;

    compass_calibrate_and_heading i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // compass state kept by the predictor
    longint decl_q, offset_q;
    bit cal_active;
    longint amin[2], amax[2], acenter[2], again[2];

    t_item pending_items[$];
    logic [16:0] expected_headings[$];
    int errors;
    int headings_seen;
    int send_idle_pct, recv_stall_pct;
    int hold_cycles;
    logic in_taken;

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint heading_angle(longint x, longint y);
        longint atan_q[24] = '{11796480, 6963869, 3679517, 1867780, 937515, 469214,
            234664, 117339, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7, 4, 2};
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd11520 <<< 12;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = shr_floor(x, i); ys = shr_floor(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_q[i];
            end else begin
                x -= ys; y += xs; z -= atan_q[i];
            end
        end
        if (z < 0) z += 64'sd23040 <<< 12;
        z = shr_floor(z + 2048, 12);
        if (z >= 23040) z -= 23040;
        return z;
    endfunction

    // predict the effect of one accepted item
    function automatic void predict_item(t_item it);
        longint s[2], span, g, h;
        s[0] = it.sx; s[1] = it.sy;
        case (it.kind)
            KIND_START: begin
                for (int i = 0; i < 2; i++) begin
                    amin[i] = s[i]; amax[i] = s[i];
                end
                cal_active = 1;
            end
            KIND_FINISH: begin
                for (int i = 0; i < 2; i++) begin
                    span = amax[i] - amin[i];
                    acenter[i] = shr_floor(amax[i] + amin[i], 1);
                    if (span <= 0) again[i] = (64'sd1 <<< 27) - 1;
                    else begin
                        g = ((64'sd1 <<< 26) + span / 2) / span;
                        again[i] = g > (64'sd1 <<< 27) - 1 ? (64'sd1 <<< 27) - 1 : g;
                    end
                end
                cal_active = 0;
            end
            KIND_SAMPLE: begin
                if (cal_active) begin
                    for (int i = 0; i < 2; i++) begin
                        if (s[i] < amin[i]) amin[i] = s[i];
                        if (s[i] > amax[i]) amax[i] = s[i];
                    end
                end else begin
                    h = heading_angle((s[0] - acenter[0]) * again[0],
                                      (s[1] - acenter[1]) * again[1]) + decl_q + offset_q;
                    expected_headings.push_back(h[16:0]);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $time);
        errors++;
    endtask

    // input transfer seen at the rising edge
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    // driver: offers queued items and drives receiver ready, changes at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                predict_item(pending_items.pop_front());
            end
            if (!s_axis_tvalid || in_taken) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_items[0].kind;
                    s_axis_tdata <= {pending_items[0].sy, pending_items[0].sx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off counter
    always @(negedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor: checks each heading transfer at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            headings_seen++;
            if (expected_headings.size() == 0)
                report_mismatch("unexpected heading", m_axis_tdata[16:0], 17'd0);
            else begin
                logic [16:0] want;
                want = expected_headings.pop_front();
                if (m_axis_tdata[16:0] !== want)
                    report_mismatch("heading", m_axis_tdata[16:0], want);
            end
        end
    end

    task automatic add_item(logic [1:0] k, int x, int y);
        t_item it;
        it.kind = k; it.sx = x[15:0]; it.sy = y[15:0];
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_headings.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == CFG_DECLINATION) decl_q = value; else offset_q = value;
    endtask

    function automatic int rand_sample();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32767 : -32768;
            1: return int'($urandom_range(200)) - 100;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // random phase: mostly heading samples, with some calibration runs and stray commands
    task automatic random_block(int n);
        int x, y, w;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(99);
            if (w < 6) begin
                add_item(KIND_START, rand_sample(), rand_sample());
                for (int j = $urandom_range(6); j > 0; j--)
                    add_item(KIND_SAMPLE, rand_sample(), rand_sample());
                if ($urandom_range(9) != 0) add_item(KIND_FINISH, rand_sample(), rand_sample());
            end else if (w < 8) begin
                add_item($urandom_range(1) ? KIND_FINISH : KIND_IGNORED,
                         rand_sample(), rand_sample());
            end else begin
                x = rand_sample(); y = rand_sample();
                add_item(KIND_SAMPLE, x, y);
            end
        end
    endtask

    int dvals[6] = '{704, -11520, 11520, 0, -5000, 9000};
    int ovals[6] = '{2240, 11520, -11520, 0, 7000, -300};

    initial begin
        i_rst_n = 1'b0; i_cfg_wen = 1'b0; i_cfg_idx = CFG_DECLINATION; i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = KIND_SAMPLE;
        m_axis_tready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        errors = 0; headings_seen = 0;
        decl_q = 704; offset_q = 2240; cal_active = 0;
        for (int i = 0; i < 2; i++) begin
            amin[i] = 0; amax[i] = 0; acenter[i] = 0; again[i] = 65536;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: reset gain headings, zero vector, extremes, calibration cases
        add_item(KIND_SAMPLE, 0, 0);
        add_item(KIND_SAMPLE, 32767, 0);
        add_item(KIND_SAMPLE, -32768, 0);
        add_item(KIND_SAMPLE, 0, -32768);
        add_item(KIND_SAMPLE, -32768, -1);
        add_item(KIND_SAMPLE, -32768, 32767);
        add_item(KIND_IGNORED, 123, -456);
        add_item(KIND_FINISH, 5, 5);
        add_item(KIND_SAMPLE, 3, -2);
        add_item(KIND_START, 100, -100);
        add_item(KIND_START, -32768, 32767);
        add_item(KIND_SAMPLE, 32767, -32768);
        add_item(KIND_SAMPLE, 0, 0);
        add_item(KIND_FINISH, 0, 0);
        add_item(KIND_SAMPLE, 32767, 32767);
        add_item(KIND_SAMPLE, -32768, -32768);
        add_item(KIND_START, 7, 7);
        add_item(KIND_FINISH, 0, 0);
        add_item(KIND_SAMPLE, 7, 8);
        add_item(KIND_SAMPLE, 6, 7);
        add_item(KIND_START, 0, 0);
        add_item(KIND_SAMPLE, 1, 1);
        add_item(KIND_FINISH, 0, 0);
        add_item(KIND_SAMPLE, 1, 0);
        drain();

        // random phases across idling patterns and register settings
        for (int p = 0; p < 6; p++) begin
            write_cfg(CFG_DECLINATION, dvals[p]);
            write_cfg(CFG_OFFSET, ovals[p]);
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 59; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 59; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (p == 4) hold_cycles = 600;
            random_block(230);
            drain();
        end

        $display("covered calibration runs, commands, extreme samples and %0d headings",
                 headings_seen);
        $display("over six declination and offset settings with random backpressure");
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: compass_calibrate_and_heading.f
+incdir+rtl
rtl/cah_pkg.sv
rtl/cah_ctrl.sv
rtl/cah_dp.sv
rtl/compass_calibrate_and_heading.sv
tb/compass_calibrate_and_heading_tb.sv
